// ----- sv/spf_pkg.sv -----
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants of the path point spacing filter
// Fixed field widths, register reset value, result queue depth and the
// write strobes that pass from the decision logic to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spf_pkg;

  // fixed field widths
  localparam int HEADING_W = 16;
  localparam int KIND_W    = 8;
  localparam int SPACING_W = 16;
  localparam int SPACING_SQ_W = 2 * SPACING_W;

  // spacing register after reset
  localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd10;

  // result queue entries (power of two)
  localparam int QUEUE_DEPTH = 4;

  // write strobes into the result queue; second is only set with first
  typedef struct packed {
    logic wr_first;
    logic wr_second;
  } spf_push_t;

endpackage : spf_pkg

`default_nettype wire

// ----- sv/path_point_spacing_filter.sv -----
// ----------------------------------------------------------------------------
// path_point_spacing_filter: thins a stream of path points by spacing
// Keeps the first point of each path and every point farther than the
// spacing register from the last kept point; merges the rest into it.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on the in_ valid/ready channel, kept points leave on the
//   out_ valid/ready channel, the spacing is written on the cfg_ channel
//   (always ready; write only while the block is idle).
//   One point is accepted per cycle while in_ready is high. The spacing
//   test and hold update run on the input register once the queue has
//   room, and any word it yields is written into the result queue and
//   offered on out_ from there.
//   A kept point is held back until the next kept point or the path end, so
//   it leaves when a later point is processed; a last point kept past a
//   held point yields two words, pushed into the queue together.
//   The input register advances only while the queue holds two words or
//   fewer, so with a stalled receiver in_ready drops once the input register
//   holds a point and three or four words wait; nothing is lost.
//   Reset (rst_n low, synchronous) empties the queue, drops any held point
//   and sets the spacing to 10.
// ----------------------------------------------------------------------------
`default_nettype none

module path_point_spacing_filter
  import spf_pkg::*;
#(
  parameter int POS_WIDTH   = 32,
  parameter int SPEED_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [SPACING_W-1:0]   cfg_min_spacing,
  // point input
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [POS_WIDTH-1:0]   in_pos_x,
  input  wire logic [POS_WIDTH-1:0]   in_pos_y,
  input  wire logic [POS_WIDTH-1:0]   in_pos_z,
  input  wire logic [SPEED_WIDTH-1:0] in_speed,
  input  wire logic [HEADING_W-1:0]   in_heading,
  input  wire logic [KIND_W-1:0]      in_point_kind,
  input  wire logic                   in_last_point,
  // result output
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [POS_WIDTH-1:0]        out_x,
  output logic [POS_WIDTH-1:0]        out_y,
  output logic [POS_WIDTH-1:0]        out_z,
  output logic [SPEED_WIDTH-1:0]      out_speed,
  output logic [HEADING_W-1:0]        out_heading,
  output logic [KIND_W-1:0]           out_kind,
  output logic                        out_path_end
);

  localparam int RES_W = 3 * POS_WIDTH + SPEED_WIDTH + HEADING_W + KIND_W + 1;

  // configuration registers
  logic [SPACING_W-1:0]    spacing_r;
  logic [SPACING_SQ_W-1:0] spacing_sq_r;

  // input register
  logic                   in_v_r;
  logic                   in_v_nxt;
  logic [POS_WIDTH-1:0]   in_x_r;
  logic [POS_WIDTH-1:0]   in_y_r;
  logic [POS_WIDTH-1:0]   in_z_r;
  logic [SPEED_WIDTH-1:0] in_speed_r;
  logic [HEADING_W-1:0]   in_heading_r;
  logic [KIND_W-1:0]      in_kind_r;
  logic                   in_last_r;

  // held point
  logic                   hold_v_r;
  logic                   hold_v_nxt;
  logic [POS_WIDTH-1:0]   hold_x_r;
  logic [POS_WIDTH-1:0]   hold_x_nxt;
  logic [POS_WIDTH-1:0]   hold_y_r;
  logic [POS_WIDTH-1:0]   hold_y_nxt;
  logic [POS_WIDTH-1:0]   hold_z_r;
  logic [POS_WIDTH-1:0]   hold_z_nxt;
  logic [SPEED_WIDTH-1:0] hold_speed_r;
  logic [SPEED_WIDTH-1:0] hold_speed_nxt;
  logic [HEADING_W-1:0]   hold_heading_r;
  logic [HEADING_W-1:0]   hold_heading_nxt;
  logic [KIND_W-1:0]      hold_kind_r;
  logic [KIND_W-1:0]      hold_kind_nxt;

  // decision and queue signals
  logic              in_accept;
  logic              go;
  logic              far;
  logic              keep;
  logic              fifo_room;
  spf_push_t         push;
  logic [RES_W-1:0]  res_old;
  logic [RES_W-1:0]  res_new;
  logic [RES_W-1:0]  wr_first_data;
  logic [RES_W-1:0]  out_data;

  // configuration: keep the squared spacing alongside the spacing
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r    <= SPACING_RESET;
      spacing_sq_r <= SPACING_SQ_W'(SPACING_RESET * SPACING_RESET);
    end else if (cfg_valid && cfg_ready) begin
      spacing_r    <= cfg_min_spacing;
      spacing_sq_r <= cfg_min_spacing * cfg_min_spacing;
    end
  end

  // input register: advance when the queue can take two words
  assign go        = in_v_r && fifo_room;
  assign in_ready  = !in_v_r || go;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_accept) begin
      in_v_nxt = 1'b1;
    end else if (go) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_x_r       <= in_pos_x;
      in_y_r       <= in_pos_y;
      in_z_r       <= in_pos_z;
      in_speed_r   <= in_speed;
      in_heading_r <= in_heading;
      in_kind_r    <= in_point_kind;
      in_last_r    <= in_last_point;
    end
  end

  // spacing test against the held point
  spf_spacing_check #(
    .POS_WIDTH (POS_WIDTH)
  ) u_check (
    .pt_x       (in_x_r),
    .pt_y       (in_y_r),
    .hold_x     (hold_x_r),
    .hold_y     (hold_y_r),
    .spacing    (spacing_r),
    .spacing_sq (spacing_sq_r),
    .far        (far)
  );

  // update the held point: load a kept point, lower speed on a merge
  assign keep = !hold_v_r || far;

  always_comb begin
    hold_v_nxt       = hold_v_r;
    hold_x_nxt       = hold_x_r;
    hold_y_nxt       = hold_y_r;
    hold_z_nxt       = hold_z_r;
    hold_speed_nxt   = hold_speed_r;
    hold_heading_nxt = hold_heading_r;
    hold_kind_nxt    = hold_kind_r;
    if (go) begin
      if (keep) begin
        hold_x_nxt       = in_x_r;
        hold_y_nxt       = in_y_r;
        hold_z_nxt       = in_z_r;
        hold_speed_nxt   = in_speed_r;
        hold_heading_nxt = in_heading_r;
        hold_kind_nxt    = in_kind_r;
      end else if ($signed(in_speed_r) < $signed(hold_speed_r)) begin
        hold_speed_nxt = in_speed_r;
      end
      hold_v_nxt = !in_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_x_r       <= hold_x_nxt;
    hold_y_r       <= hold_y_nxt;
    hold_z_r       <= hold_z_nxt;
    hold_speed_r   <= hold_speed_nxt;
    hold_heading_r <= hold_heading_nxt;
    hold_kind_r    <= hold_kind_nxt;
  end

  // form result words: the displaced held point, then the path end
  assign res_old = {hold_x_r, hold_y_r, hold_z_r, hold_speed_r, hold_heading_r,
                    hold_kind_r, 1'b0};
  assign res_new = {hold_x_nxt, hold_y_nxt, hold_z_nxt, hold_speed_nxt,
                    hold_heading_nxt, hold_kind_nxt, 1'b1};

  assign wr_first_data  = (hold_v_r && far) ? res_old : res_new;
  assign push.wr_first  = go && ((hold_v_r && far) || in_last_r);
  assign push.wr_second = go && hold_v_r && far && in_last_r;

  spf_out_fifo #(
    .DATA_W (RES_W)
  ) u_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .wr_data_first  (wr_first_data),
    .wr_data_second (res_new),
    .room           (fifo_room),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  assign {out_x, out_y, out_z, out_speed, out_heading, out_kind, out_path_end} = out_data;

  // a queue without room for two words holds the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !fifo_room |-> !in_ready)
    else $error("input accepted while result queue lacks room");

  // squared spacing tracks every write
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=>
      spacing_sq_r == SPACING_SQ_W'(spacing_r) * SPACING_SQ_W'(spacing_r))
    else $error("squared spacing out of step with spacing");

  // a path end leaves nothing held
  assert property (@(posedge clk) disable iff (!rst_n)
    go && in_last_r |=> !hold_v_r)
    else $error("point still held after path end");

  // the first point of a path is held unless it ends the path
  assert property (@(posedge clk) disable iff (!rst_n)
    go && !hold_v_r && !in_last_r |=> hold_v_r)
    else $error("first point of a path not held");

endmodule : path_point_spacing_filter

`default_nettype wire

// ----- sv/spf_spacing_check.sv -----
// ----------------------------------------------------------------------------
// spf_spacing_check: planar spacing test against the held point
// Flags a point whose x/y distance to the held point exceeds the spacing,
// using per-axis bounds first and a squared-sum compare otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_spacing_check
  import spf_pkg::*;
#(
  parameter int POS_WIDTH = 32
) (
  input  wire logic [POS_WIDTH-1:0]    pt_x,
  input  wire logic [POS_WIDTH-1:0]    pt_y,
  input  wire logic [POS_WIDTH-1:0]    hold_x,
  input  wire logic [POS_WIDTH-1:0]    hold_y,
  input  wire logic [SPACING_W-1:0]    spacing,
  input  wire logic [SPACING_SQ_W-1:0] spacing_sq,
  output logic                         far
);

  logic signed [POS_WIDTH:0]   diff_x;
  logic signed [POS_WIDTH:0]   diff_y;
  logic        [POS_WIDTH:0]   neg_x;
  logic        [POS_WIDTH:0]   neg_y;
  logic        [POS_WIDTH-1:0] abs_x;
  logic        [POS_WIDTH-1:0] abs_y;
  logic        [POS_WIDTH-1:0] spacing_ext;
  logic                        axis_far;
  logic [SPACING_SQ_W-1:0]     sq_x;
  logic [SPACING_SQ_W-1:0]     sq_y;
  logic [SPACING_SQ_W:0]       sq_sum;

  // take signed differences one bit wider so they never wrap
  assign diff_x = $signed({pt_x[POS_WIDTH-1], pt_x}) - $signed({hold_x[POS_WIDTH-1], hold_x});
  assign diff_y = $signed({pt_y[POS_WIDTH-1], pt_y}) - $signed({hold_y[POS_WIDTH-1], hold_y});
  assign neg_x  = (POS_WIDTH+1)'(-diff_x);
  assign neg_y  = (POS_WIDTH+1)'(-diff_y);

  // magnitudes stay below 2^POS_WIDTH
  assign abs_x = diff_x[POS_WIDTH] ? neg_x[POS_WIDTH-1:0] : diff_x[POS_WIDTH-1:0];
  assign abs_y = diff_y[POS_WIDTH] ? neg_y[POS_WIDTH-1:0] : diff_y[POS_WIDTH-1:0];

  // decide at once when one axis alone is past the spacing
  assign spacing_ext = POS_WIDTH'(spacing);
  assign axis_far    = (abs_x > spacing_ext) || (abs_y > spacing_ext);

  // both axes fit the spacing width here, so the squares are exact
  assign sq_x   = abs_x[SPACING_W-1:0] * abs_x[SPACING_W-1:0];
  assign sq_y   = abs_y[SPACING_W-1:0] * abs_y[SPACING_W-1:0];
  assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};

  assign far = axis_far || (sq_sum > {1'b0, spacing_sq});

endmodule : spf_spacing_check

`default_nettype wire

// ----- sv/spf_out_fifo.sv -----
// ----------------------------------------------------------------------------
// spf_out_fifo: result queue of the path point spacing filter
// Takes up to two result words per cycle and hands out one per cycle, when
// out_ready is high, on a valid/ready channel. Reports room when two more fit.
// ----------------------------------------------------------------------------
`default_nettype none

module spf_out_fifo
  import spf_pkg::*;
#(
  parameter int DATA_W = 137
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire spf_push_t         push,
  input  wire logic [DATA_W-1:0] wr_data_first,
  input  wire logic [DATA_W-1:0] wr_data_second,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_plus1;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              pop;

  assign out_valid    = (count_r != '0);
  assign out_data     = mem_r[rd_ptr_r];
  assign pop          = out_valid && out_ready;
  assign room         = (count_r <= CNT_W'(QUEUE_DEPTH - 2));
  assign wr_ptr_plus1 = PTR_W'(wr_ptr_r + 1'b1);

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.wr_first && push.wr_second) begin
      wr_ptr_nxt = PTR_W'(wr_ptr_r + 2'd2);
    end else if (push.wr_first) begin
      wr_ptr_nxt = wr_ptr_plus1;
    end
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = CNT_W'(count_r + CNT_W'(push.wr_first) + CNT_W'(push.wr_second)
                        - CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store words; the second lands just after the first
  always_ff @(posedge clk) begin
    if (push.wr_first) begin
      mem_r[wr_ptr_r] <= wr_data_first;
    end
    if (push.wr_second) begin
      mem_r[wr_ptr_plus1] <= wr_data_second;
    end
  end

endmodule : spf_out_fifo

`default_nettype wire

// ----- tb/path_point_spacing_filter_tb.sv -----
// ----------------------------------------------------------------------------
// path_point_spacing_filter_tb: self-checking bench for the spacing filter
// Streams path points through the filter under random idles on both sides.
// A built-in thinning predictor computes the kept words, and the monitor
// checks each word field by field. Phases sweep the spacing register,
// including zero and full scale.
// ----------------------------------------------------------------------------

module path_point_spacing_filter_tb;
  import spf_pkg::*;

  localparam int POS_W   = 32;
  localparam int SPEED_W = 16;
  localparam int SETTLE  = 8;
  localparam int LIMIT   = 400000;
  localparam int PHASES  = 10;
  localparam int PHASE_POINTS = 200;

  typedef struct {
    logic [POS_W-1:0]     x;
    logic [POS_W-1:0]     y;
    logic [POS_W-1:0]     z;
    logic [SPEED_W-1:0]   speed;
    logic [HEADING_W-1:0] heading;
    logic [KIND_W-1:0]    kind;
    logic                 last;
  } point_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [SPACING_W-1:0] cfg_min_spacing = '0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [POS_W-1:0]     in_pos_x = '0;
  logic [POS_W-1:0]     in_pos_y = '0;
  logic [POS_W-1:0]     in_pos_z = '0;
  logic [SPEED_W-1:0]   in_speed = '0;
  logic [HEADING_W-1:0] in_heading = '0;
  logic [KIND_W-1:0]    in_point_kind = '0;
  logic                 in_last_point = 1'b0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [POS_W-1:0]     out_x;
  logic [POS_W-1:0]     out_y;
  logic [POS_W-1:0]     out_z;
  logic [SPEED_W-1:0]   out_speed;
  logic [HEADING_W-1:0] out_heading;
  logic [KIND_W-1:0]    out_kind;
  logic                 out_path_end;

  path_point_spacing_filter #(
    .POS_WIDTH   (POS_W),
    .SPEED_WIDTH (SPEED_W)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_min_spacing (cfg_min_spacing),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_speed        (in_speed),
    .in_heading      (in_heading),
    .in_point_kind   (in_point_kind),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_speed       (out_speed),
    .out_heading     (out_heading),
    .out_kind        (out_kind),
    .out_path_end    (out_path_end)
  );

  // 2 time unit clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // stimulus and bookkeeping
  point_t point_q[$];     // points waiting for the driver
  point_t kept_q[$];      // kept words still to come out
  int     pushed_cnt   = 0;
  int     accepted_cnt = 0;
  int     mismatch_cnt = 0;
  int     cycle_cnt    = 0;
  bit     in_took  = 1'b0;
  bit     out_took = 1'b0;

  // idle shaping, set per phase
  int gap_max      = 3;
  int stall_max    = 3;
  int in_gap       = 0;
  int out_wait     = 0;
  int hold_off     = 0;
  int hold_off_req = 0;

  // thinning predictor state
  logic [SPACING_W-1:0] spacing = SPACING_RESET;
  point_t               held_pt;
  bit                   held_valid = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  // planar distance to the held point strictly above the spacing
  function automatic bit beyond_spacing(point_t p);
    longint dx, dy, s;
    dx = longint'($signed(p.x)) - longint'($signed(held_pt.x));
    dy = longint'($signed(p.y)) - longint'($signed(held_pt.y));
    s  = longint'(spacing);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx > s || dy > s) return 1'b1;
    return dx * dx + dy * dy > s * s;
  endfunction

  // keep, merge or close the path for one accepted point
  task automatic thin_point(input point_t p);
    point_t w;
    if (!held_valid) begin
      held_pt    = p;
      held_valid = 1'b1;
    end else if (beyond_spacing(p)) begin
      w      = held_pt;
      w.last = 1'b0;
      kept_q.insert(kept_q.size(), w);
      held_pt = p;
    end else if ($signed(p.speed) < $signed(held_pt.speed)) begin
      held_pt.speed = p.speed;
    end
    if (p.last) begin
      w      = held_pt;
      w.last = 1'b1;
      kept_q.insert(kept_q.size(), w);
      held_valid = 1'b0;
    end
  endtask

  task automatic check_word(input point_t got);
    point_t want;
    if (kept_q.size() == 0) begin
      report_mismatch("word with nothing expected, x", 64'(got.x), 64'(0));
      return;
    end
    want = kept_q.pop_front();
    if (got.x !== want.x) report_mismatch("out_x", 64'(got.x), 64'(want.x));
    if (got.y !== want.y) report_mismatch("out_y", 64'(got.y), 64'(want.y));
    if (got.z !== want.z) report_mismatch("out_z", 64'(got.z), 64'(want.z));
    if (got.speed !== want.speed)
      report_mismatch("out_speed", 64'(got.speed), 64'(want.speed));
    if (got.heading !== want.heading)
      report_mismatch("out_heading", 64'(got.heading), 64'(want.heading));
    if (got.kind !== want.kind) report_mismatch("out_kind", 64'(got.kind), 64'(want.kind));
    if (got.last !== want.last)
      report_mismatch("out_path_end", 64'(got.last), 64'(want.last));
  endtask

  // monitor: sample handshakes at the rising edge
  always @(posedge clk) begin
    point_t p;
    in_took  = rst_n && in_valid && in_ready;
    out_took = rst_n && out_valid && out_ready;
    if (rst_n && cfg_valid && cfg_ready) spacing = cfg_min_spacing;
    if (out_took) begin
      p.x = out_x; p.y = out_y; p.z = out_z;
      p.speed = out_speed; p.heading = out_heading; p.kind = out_kind;
      p.last = out_path_end;
      check_word(p);
    end
    if (in_took) begin
      p.x = in_pos_x; p.y = in_pos_y; p.z = in_pos_z;
      p.speed = in_speed; p.heading = in_heading; p.kind = in_point_kind;
      p.last = in_last_point;
      thin_point(p);
      accepted_cnt++;
    end
  end

  // driver: offer the next point after its drawn gap
  always @(negedge clk) begin
    point_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (point_q.size() > 0) begin
        p = point_q.pop_front();
        in_pos_x      <= p.x;
        in_pos_y      <= p.y;
        in_pos_z      <= p.z;
        in_speed      <= p.speed;
        in_heading    <= p.heading;
        in_point_kind <= p.kind;
        in_last_point <= p.last;
        in_valid      <= 1'b1;
        in_gap        = $urandom_range(0, gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: per-word stall, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_req > 0) begin
      hold_off     = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off--;
    end else begin
      if (out_took) out_wait = $urandom_range(0, stall_max);
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                      input logic [POS_W-1:0] z, input logic [SPEED_W-1:0] spd,
                      input logic [HEADING_W-1:0] hd, input logic [KIND_W-1:0] kd,
                      input logic lst);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    p.speed = spd; p.heading = hd; p.kind = kd; p.last = lst;
    point_q.insert(point_q.size(), p);
    pushed_cnt++;
  endtask

  // hold off until every point is in and every word is out
  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || kept_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [SPACING_W-1:0] v);
    @(negedge clk);
    cfg_min_spacing <= v;
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random walk path: steps around the spacing so points both merge and keep
  task automatic add_path(input int len, input int step, input bit close);
    logic [POS_W-1:0] x, y;
    int i;
    x = $urandom;
    y = $urandom;
    for (i = 0; i < len; i++) begin
      send(x, y, $urandom, $urandom, $urandom, $urandom, close && (i == len - 1));
      x = x + ($urandom_range(0, 2 * step) - step);
      y = y + ($urandom_range(0, 2 * step) - step);
    end
  endtask

  initial begin
    int ph, base, step;
    logic [SPACING_W-1:0] sp;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset spacing of 10
    // one point path at the field extremes
    send(32'h7fffffff, 32'h80000000, 32'h80000000, 16'h8000, 16'hffff, 8'hff, 1'b1);
    // merges at and under the spacing, keep just past it, merged last point
    send(0, 0, 32'h7fffffff, 100, 16'h0000, 8'h00, 1'b0);
    send(3, 4, 1, 50, 1, 1, 1'b0);
    send(6, 8, 2, 200, 2, 2, 1'b0);
    send(11, 0, 3, 16'h7fff, 3, 3, 1'b0);
    send(11, 10, 4, -5, 4, 4, 1'b1);
    // kept last point gives two words
    send(0, 0, 5, 7, 5, 5, 1'b0);
    send(100, 0, 6, 8, 6, 6, 1'b1);
    // squared sum decides while both axes are within the spacing
    send(0, 0, 7, 0, 7, 7, 1'b0);
    send(8, 8, 8, 1, 8, 8, 1'b0);
    send(15, 15, 9, -1, 9, 9, 1'b0);
    send(32'h7fffffff, 32'h80000000, 10, 2, 10, 10, 1'b1);
    // opposite extremes of x in one path
    send(32'h80000000, 0, 11, 3, 11, 11, 1'b0);
    send(32'h7fffffff, 0, 12, 4, 12, 12, 1'b1);
    wait_drained();

    // zero spacing merges only identical x and y
    write_spacing('0);
    send(5, 5, 13, 30, 13, 13, 1'b0);
    send(5, 5, 14, 20, 14, 14, 1'b0);
    send(5, 6, 15, 40, 15, 15, 1'b0);
    send(5, 6, 16, 16'h8000, 16, 16, 1'b1);
    wait_drained();

    // full scale spacing
    write_spacing(16'hffff);
    send(0, 0, 17, 9, 17, 17, 1'b0);
    send(65535, 0, 18, 8, 18, 18, 1'b0);
    send(0, 65535, 19, 10, 19, 19, 1'b0);
    send(46341, 46341, 20, 1, 20, 20, 1'b1);
    wait_drained();

    // random phases, each at a spacing of its own
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       sp = '0;
        1:       sp = 16'hffff;
        2:       sp = SPACING_RESET;
        default: sp = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : $urandom;
      endcase
      write_spacing(sp);
      gap_max   = ($urandom_range(0, 2) == 0) ? 10 : $urandom_range(0, 3);
      stall_max = ($urandom_range(0, 2) == 0) ? 10 : $urandom_range(0, 3);
      if (ph == 2) begin
        // back-to-back points into a receiver that holds off
        gap_max      = 0;
        hold_off_req = 300;
      end else if (ph == 3) begin
        gap_max   = 0;
        stall_max = 0;
      end
      base = pushed_cnt;
      step = int'(sp) + int'(sp) / 2 + 2;
      while (pushed_cnt - base < PHASE_POINTS) begin
        if ($urandom_range(0, 9) == 0)
          send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(0, 3) == 0);
        else
          add_path($urandom_range(1, 12),
                   ($urandom_range(0, 7) == 0) ? 32'h3fffffff >> $urandom_range(0, 24)
                                                : step,
                   1'b1);
      end
      // leave a path open across the spacing change now and then
      if ($urandom_range(0, 2) == 0) add_path($urandom_range(1, 4), step, 1'b0);
      wait_drained();
    end

    if (kept_q.size() != 0)
      report_mismatch("words never seen", 64'(kept_q.size()), 64'(0));
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
